### src/eps_pkg.sv
// eps_pkg: shared types, constants and fixed-point helpers of the spatial transform
// no dependencies; imported by every module of the block
`default_nettype none

package eps_pkg;

  // internal fixed point: Q30 held in 36 signed bits
  localparam int Q30_W = 36;
  typedef logic signed [Q30_W-1:0] q30_t;
  typedef logic signed [31:0] word_t;

  localparam q30_t QONE = 36'sd1073741824;

  // fraction bits of the output words
  localparam int FRAC_BITS = 16;

  // odd sine polynomial in the half angle, Q30, lowest order first
  localparam q30_t SINE_POLY [7] = '{
    36'sd1686629713, 36'sd693598669, 36'sd85569306, 36'sd5026995,
    36'sd172272, 36'sd3864, 36'sd61
  };

  // pipeline depths of the parts
  localparam int SINE_DEPTH = 9;
  localparam int QN_DEPTH   = 36;
  localparam int DIV_DEPTH  = 33;
  localparam int MERGE_DEPTH = 4;

  // rows of one transform
  localparam logic [2:0] FIRST_LOW_ROW = 3'd3;
  localparam logic [2:0] LAST_ROW      = 3'd5;

  localparam word_t WORD_MAX = 32'sh7fffffff;
  localparam word_t WORD_MIN = 32'sh80000000;

  // Q30 product with floor rounding
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [2*Q30_W-1:0] p;
    p = a * b;
    return p[Q30_W+29:30];
  endfunction

endpackage

`default_nettype wire

### src/eps_if.sv
// eps_if: valid/ready channel interfaces for pose input and row output beats
// no dependencies; the word fields are plain signed 32-bit logic
`default_nettype none

interface eps_pose_if #(parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_x;
  logic signed [ANGLE_BITS-1:0] angle_y;
  logic signed [ANGLE_BITS-1:0] angle_z;
  logic signed [31:0]           pos_x;
  logic signed [31:0]           pos_y;
  logic signed [31:0]           pos_z;

  modport source (output valid, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface eps_row_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic signed [31:0] col4;
  logic signed [31:0] col5;
  logic               last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, col4, col5, last_row,
                  input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, col4, col5, last_row,
                  output ready);
endinterface

`default_nettype wire

### src/eps_sine_lane.sv
// eps_sine_lane: one angle lane, half-angle sine and cosine by pipelined Horner steps
// depends on eps_pkg (q30_t, qmul, SINE_POLY)
`default_nettype none

module eps_sine_lane #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output eps_pkg::q30_t                sin_o,
  output eps_pkg::q30_t                cos_o
);
  import eps_pkg::*;

  localparam int SHIFT = 31 - ANGLE_BITS;

  q30_t u_in, v_in;
  q30_t u_q [8];
  q30_t v_q [8];
  q30_t u2_q [6];
  q30_t v2_q [6];
  q30_t acc_s_q [6];
  q30_t acc_c_q [6];
  q30_t sin_q, cos_q;

  // half angle in Q30 and its complement for the cosine
  assign u_in = q30_t'(angle_i) <<< SHIFT;
  assign v_in = QONE - (u_in[Q30_W-1] ? -u_in : u_in);

  // capture and square
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0]  <= u_in;
      v_q[0]  <= v_in;
      u_q[1]  <= u_q[0];
      v_q[1]  <= v_q[0];
      u2_q[0] <= qmul(u_q[0], u_q[0]);
      v2_q[0] <= qmul(v_q[0], v_q[0]);
    end
  end

  // horner steps, one coefficient per stage
  for (genvar j = 0; j < 6; j++) begin : g_horner
    q30_t prev_s, prev_c;
    if (j == 0) begin : g_first
      assign prev_s = SINE_POLY[6];
      assign prev_c = SINE_POLY[6];
    end else begin : g_next
      assign prev_s = acc_s_q[j-1];
      assign prev_c = acc_c_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_s_q[j] <= SINE_POLY[5-j] - qmul(prev_s, u2_q[j]);
        acc_c_q[j] <= SINE_POLY[5-j] - qmul(prev_c, v2_q[j]);
        u_q[j+2]   <= u_q[j+1];
        v_q[j+2]   <= v_q[j+1];
      end
    end

    if (j < 5) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          u2_q[j+1] <= u2_q[j];
          v2_q[j+1] <= v2_q[j];
        end
      end
    end
  end

  // final multiply by the odd power
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= qmul(acc_s_q[5], u_q[7]);
      cos_q <= qmul(acc_c_q[5], v_q[7]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

### src/eps_quat_norm.sv
// eps_quat_norm: merges the three angle lanes into a quaternion and takes its norm
// depends on eps_pkg (q30_t, qmul); root by a 32-stage digit pipeline
`default_nettype none

module eps_quat_norm (
  input  logic          clk_i,
  input  logic          en_i,
  input  eps_pkg::q30_t sin_i [3],
  input  eps_pkg::q30_t cos_i [3],
  output eps_pkg::q30_t quat_o [4],
  output logic [31:0]   norm_o
);
  import eps_pkg::*;

  q30_t cc_q, ss_q, sc_q, cs_q, s2_q, c2_q;
  q30_t quat_b_q [4];
  q30_t quat_c_q [4];
  logic [63:0] sq_q [4];
  logic [63:0] v_q [33];
  logic [63:0] r_q [33];
  q30_t qc_q [33][4];

  function automatic logic [63:0] square64(input q30_t a);
    logic signed [2*Q30_W-1:0] p;
    p = a * a;
    return p[63:0];
  endfunction

  // pair products of the first two axes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= qmul(cos_i[0], cos_i[1]);
      ss_q <= qmul(sin_i[0], sin_i[1]);
      sc_q <= qmul(sin_i[0], cos_i[1]);
      cs_q <= qmul(cos_i[0], sin_i[1]);
      s2_q <= sin_i[2];
      c2_q <= cos_i[2];
    end
  end

  // quaternion w, x, y, z
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_b_q[0] <= qmul(cc_q, c2_q) + qmul(ss_q, s2_q);
      quat_b_q[1] <= qmul(sc_q, c2_q) - qmul(cs_q, s2_q);
      quat_b_q[2] <= qmul(cs_q, c2_q) + qmul(sc_q, s2_q);
      quat_b_q[3] <= qmul(cc_q, s2_q) - qmul(ss_q, c2_q);
    end
  end

  // exact squares, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i]     <= square64(quat_b_q[i]);
        quat_c_q[i] <= quat_b_q[i];
      end
      v_q[0]  <= sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];
      r_q[0]  <= '0;
      qc_q[0] <= quat_c_q;
    end
  end

  // root digits, two bits of the radicand per stage
  for (genvar k = 0; k < 32; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = r_q[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[k] >= trial) begin
          v_q[k+1] <= v_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          v_q[k+1] <= v_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        qc_q[k+1] <= qc_q[k];
      end
    end
  end

  assign quat_o = qc_q[32];
  assign norm_o = r_q[32][31:0];

endmodule

`default_nettype wire

### src/eps_div_lane.sv
// eps_div_lane: one quaternion component divided by the norm, one quotient bit a stage
// depends on eps_pkg (q30_t); truncates toward zero, falls back when the norm is zero
`default_nettype none

module eps_div_lane (
  input  logic          clk_i,
  input  logic          en_i,
  input  eps_pkg::q30_t q_i,
  input  logic [31:0]   norm_i,
  input  eps_pkg::q30_t fallback_i,
  output eps_pkg::q30_t res_o
);
  import eps_pkg::*;

  logic            neg_in;
  logic [Q30_W-1:0] mag_in;
  logic [65:0]     num_in;

  logic [31:0] rem_q [32];
  logic [31:0] quot_q [32];
  logic [31:0] low_q [32];
  logic [31:0] norm_q [32];
  logic        neg_q [32];
  q30_t        fb_q [32];
  q30_t        res_q;

  // magnitude scaled by one in Q30
  assign neg_in = q_i[Q30_W-1];
  assign mag_in = neg_in ? Q30_W'(-q_i) : Q30_W'(q_i);
  assign num_in = {mag_in, 30'd0};

  for (genvar k = 0; k < 32; k++) begin : g_step
    logic [31:0] rem_p, quot_p, low_p, norm_p;
    logic        neg_p;
    q30_t        fb_p;
    logic [32:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_p  = num_in[63:32];
      assign quot_p = '0;
      assign low_p  = num_in[31:0];
      assign norm_p = norm_i;
      assign neg_p  = neg_in;
      assign fb_p   = fallback_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign quot_p = quot_q[k-1];
      assign low_p  = low_q[k-1];
      assign norm_p = norm_q[k-1];
      assign neg_p  = neg_q[k-1];
      assign fb_p   = fb_q[k-1];
    end

    assign trial = {rem_p, low_p[31]};
    assign ge    = trial >= {1'b0, norm_p};

    // restoring step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 32'(trial - {1'b0, norm_p}) : trial[31:0];
        quot_q[k] <= {quot_p[30:0], ge};
        low_q[k]  <= {low_p[30:0], 1'b0};
        norm_q[k] <= norm_p;
        neg_q[k]  <= neg_p;
        fb_q[k]   <= fb_p;
      end
    end
  end

  // sign and zero-norm fallback
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (norm_q[31] == '0) begin
        res_q <= fb_q[31];
      end else if (neg_q[31]) begin
        res_q <= -q30_t'({4'd0, quot_q[31]});
      end else begin
        res_q <= q30_t'({4'd0, quot_q[31]});
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### src/eps_merge.sv
// eps_merge: rotation matrix from the unit quaternion and the position product block
// depends on eps_pkg (q30_t, word_t, qmul, FRAC_BITS); four pipeline stages
`default_nettype none

module eps_merge (
  input  logic          clk_i,
  input  logic          en_i,
  input  eps_pkg::q30_t quat_i [4],
  input  eps_pkg::word_t pos_i [3],
  output eps_pkg::word_t rot_o [3][3],
  output eps_pkg::word_t pr_o [3][3]
);
  import eps_pkg::*;

  localparam q30_t ROUND = q30_t'(1) <<< (29 - FRAC_BITS);

  typedef logic signed [67:0] prod_t;

  q30_t  xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  word_t pos1_q [3];
  word_t pos2_q [3];
  q30_t  r_q [3][3];
  q30_t  rc_q [3][3];
  prod_t pa_q [3][3];
  prod_t pb_q [3][3];
  word_t rot_q [3][3];
  word_t pr_q [3][3];

  function automatic prod_t pmul(input word_t p, input q30_t r);
    prod_t m;
    m = p * r;
    return m;
  endfunction

  // b - a, round, saturate
  function automatic word_t pr_out(input prod_t a, input prod_t b);
    logic signed [68:0] d;
    logic signed [38:0] s;
    d = {b[67], b} - {a[67], a} + 69'sd536870912;
    s = d[68:30];
    if (s > 39'(WORD_MAX)) return WORD_MAX;
    if (s < 39'(WORD_MIN)) return WORD_MIN;
    return s[31:0];
  endfunction

  function automatic word_t rot_out(input q30_t r);
    q30_t t;
    t = (r + ROUND) >>> (30 - FRAC_BITS);
    return word_t'(t);
  endfunction

  // quaternion cross products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= qmul(quat_i[1], quat_i[1]);
      yy_q <= qmul(quat_i[2], quat_i[2]);
      zz_q <= qmul(quat_i[3], quat_i[3]);
      xy_q <= qmul(quat_i[1], quat_i[2]);
      xz_q <= qmul(quat_i[1], quat_i[3]);
      yz_q <= qmul(quat_i[2], quat_i[3]);
      wx_q <= qmul(quat_i[0], quat_i[1]);
      wy_q <= qmul(quat_i[0], quat_i[2]);
      wz_q <= qmul(quat_i[0], quat_i[3]);
      pos1_q <= pos_i;
    end
  end

  // rotation entries
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0][0] <= QONE - ((yy_q + zz_q) <<< 1);
      r_q[0][1] <= (xy_q - wz_q) <<< 1;
      r_q[0][2] <= (xz_q + wy_q) <<< 1;
      r_q[1][0] <= (xy_q + wz_q) <<< 1;
      r_q[1][1] <= QONE - ((xx_q + zz_q) <<< 1);
      r_q[1][2] <= (yz_q - wx_q) <<< 1;
      r_q[2][0] <= (xz_q - wy_q) <<< 1;
      r_q[2][1] <= (yz_q + wx_q) <<< 1;
      r_q[2][2] <= QONE - ((xx_q + yy_q) <<< 1);
      pos2_q <= pos1_q;
    end
  end

  // skew position times rotation, each entry as b - a
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        pa_q[0][j] <= pmul(pos2_q[2], r_q[1][j]);
        pb_q[0][j] <= pmul(pos2_q[1], r_q[2][j]);
        pa_q[1][j] <= pmul(pos2_q[0], r_q[2][j]);
        pb_q[1][j] <= pmul(pos2_q[2], r_q[0][j]);
        pa_q[2][j] <= pmul(pos2_q[1], r_q[0][j]);
        pb_q[2][j] <= pmul(pos2_q[0], r_q[1][j]);
      end
      rc_q <= r_q;
    end
  end

  // output words
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot_q[i][j] <= rot_out(rc_q[i][j]);
          pr_q[i][j]  <= pr_out(pa_q[i][j], pb_q[i][j]);
        end
      end
    end
  end

  assign rot_o = rot_q;
  assign pr_o  = pr_q;

endmodule

`default_nettype wire

### src/euler_pose_spatial_transform.sv
// euler_pose_spatial_transform: top level, lane pipeline plus row serialiser
// depends on eps_pkg, eps_if, eps_sine_lane, eps_quat_norm, eps_div_lane, eps_merge
`default_nettype none

// Takes one pose beat (three binary angles, three Q16.16 positions) and returns the
// 6x6 spatial transform [R, P*R; 0, R] as six row beats, last_row set on row five.
// Poses run through an 82-stage pipeline (three sine lanes, quaternion and norm,
// four divider lanes, matrix merge); a pose may enter every cycle while stages are
// free, and the six output row beats of each pose set the sustained rate. The
// pipeline stalls as a whole only when a finished matrix reaches the end while the
// previous one is still being sent.

module euler_pose_spatial_transform #(
  parameter int ANGLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eps_pose_if.sink  pose_i,
  eps_row_if.source row_o
);
  import eps_pkg::*;

  localparam int PRE = SINE_DEPTH + QN_DEPTH + DIV_DEPTH;
  localparam int LAT = PRE + MERGE_DEPTH;

  logic  en;
  logic  load;
  logic  can_load;
  logic  vld_q [LAT];
  word_t pos_q [PRE][3];

  q30_t  sin_w [3];
  q30_t  cos_w [3];
  q30_t  quat_w [4];
  logic [31:0] norm_w;
  q30_t  unit_w [4];
  word_t rot_w [3][3];
  word_t pr_w [3][3];

  logic       busy_q;
  logic [2:0] row_q;
  word_t      rot_q [3][3];
  word_t      pr_q [3][3];
  logic [1:0] rsel;
  logic       upper;
  logic       out_beat;

  // global advance: stall only if the last stage holds a matrix with nowhere to go
  assign out_beat = row_o.valid && row_o.ready;
  assign can_load = !busy_q || (out_beat && row_q == LAST_ROW);
  assign en       = !vld_q[LAT-1] || can_load;
  assign load     = en && vld_q[LAT-1];
  assign pose_i.ready = en;

  // valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pose_i.valid;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // position delay line up to the merge stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0][0] <= pose_i.pos_x;
      pos_q[0][1] <= pose_i.pos_y;
      pos_q[0][2] <= pose_i.pos_z;
      for (int k = 1; k < PRE; k++) pos_q[k] <= pos_q[k-1];
    end
  end

  // angle lanes
  eps_sine_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_x (
    .clk_i, .en_i(en), .angle_i(pose_i.angle_x), .sin_o(sin_w[0]), .cos_o(cos_w[0])
  );
  eps_sine_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_y (
    .clk_i, .en_i(en), .angle_i(pose_i.angle_y), .sin_o(sin_w[1]), .cos_o(cos_w[1])
  );
  eps_sine_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_z (
    .clk_i, .en_i(en), .angle_i(pose_i.angle_z), .sin_o(sin_w[2]), .cos_o(cos_w[2])
  );

  eps_quat_norm u_quat_norm (
    .clk_i, .en_i(en), .sin_i(sin_w), .cos_i(cos_w), .quat_o(quat_w), .norm_o(norm_w)
  );

  // divider lanes, identity quaternion on a zero norm
  for (genvar i = 0; i < 4; i++) begin : g_div
    eps_div_lane u_div (
      .clk_i,
      .en_i(en),
      .q_i(quat_w[i]),
      .norm_i(norm_w),
      .fallback_i((i == 0) ? QONE : q30_t'(0)),
      .res_o(unit_w[i])
    );
  end

  eps_merge u_merge (
    .clk_i, .en_i(en), .quat_i(unit_w), .pos_i(pos_q[PRE-1]), .rot_o(rot_w), .pr_o(pr_w)
  );

  // row serialiser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else if (out_beat) begin
      if (row_q == LAST_ROW) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  // held matrix
  always_ff @(posedge clk_i) begin
    if (load) begin
      rot_q <= rot_w;
      pr_q  <= pr_w;
    end
  end

  // row selection
  assign upper = row_q < FIRST_LOW_ROW;
  assign rsel  = upper ? row_q[1:0] : 2'(row_q - FIRST_LOW_ROW);

  assign row_o.valid     = busy_q;
  assign row_o.row_index = row_q;
  assign row_o.col0      = upper ? rot_q[rsel][0] : '0;
  assign row_o.col1      = upper ? rot_q[rsel][1] : '0;
  assign row_o.col2      = upper ? rot_q[rsel][2] : '0;
  assign row_o.col3      = upper ? pr_q[rsel][0] : rot_q[rsel][0];
  assign row_o.col4      = upper ? pr_q[rsel][1] : rot_q[rsel][1];
  assign row_o.col5      = upper ? pr_q[rsel][2] : rot_q[rsel][2];
  assign row_o.last_row  = (row_q == LAST_ROW);

  // checks
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && row_q != LAST_ROW |=> busy_q && row_q == $past(row_q) + 3'd1)
    else $error("row beat did not advance to the next row");

  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_i.valid && pose_i.ready |=> vld_q[0])
    else $error("accepted pose not tracked in the pipeline");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> vld_q[LAT-1] && busy_q)
    else $error("pipeline stalled without a waiting matrix");

  a_load_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && row_q == '0)
    else $error("matrix load did not restart at row zero");

endmodule

`default_nettype wire
